>>> design/pvc_pkg.sv
// Package for the velocity PID controller: widths, constants, datapath
// operation codes and the command and status structures.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pvc_pkg;

   localparam int DataW   = 32;
   localparam int GainW   = 16;
   localparam int TargetW = 16;
   localparam int DriveW  = 7;
   localparam int IndexW  = 2;
   localparam int MulW    = 33;
   localparam int ProdW   = 2 * MulW;
   localparam int NumW    = 60;
   localparam int DenW    = 48;
   localparam int AccW    = 52;
   localparam int CountW  = 6;

   localparam logic [MulW-1:0] VelScale  = MulW'(245760000);
   localparam logic [DriveW-1:0] DriveMax = DriveW'(127);

   localparam logic [IndexW-1:0] CSR_GAIN_P = 2'd0;
   localparam logic [IndexW-1:0] CSR_GAIN_I = 2'd1;
   localparam logic [IndexW-1:0] CSR_GAIN_D = 2'd2;
   localparam logic [IndexW-1:0] CSR_TICKS  = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_VNUM,
      OP_VDEN,
      OP_VSET,
      OP_ERR,
      OP_ISUM,
      OP_SNUM,
      OP_SSET,
      OP_ACCP,
      OP_ACCI,
      OP_ACCD,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   div_start;
   } cmd_type;

   typedef struct packed {
      logic dt_zero;
      logic div_busy;
   } status_type;

endpackage

`default_nettype wire

>>> design/pid_velocity_controller.sv
// Velocity PID controller, top level: joins the controller and the datapath.
// An item with a nonzero time delta makes two passes through the shared divider, one
// for the velocity and one for the slope; an item with a zero time delta skips both.
// A new item is taken only while the controller is idle, once the last one's result is out.
// The result waits in an output register, so a new item is taken while it is pending.
// Synchronous reset clears the loop state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module pid_velocity_controller
   import pvc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [DataW-1:0]   req_encoder_count,
   input  wire logic [DataW-1:0]          req_time_ms,
   input  wire logic signed [TargetW-1:0] req_target_rpm,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [DriveW-1:0]              rsp_drive,
   output logic signed [DataW-1:0]        rsp_velocity_q8,
   output logic signed [DataW-1:0]        rsp_speed_error,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [IndexW-1:0]         csr_index,
   input  wire logic [GainW-1:0]          csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   pvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pvc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_encoder_count (req_encoder_count),
      .req_time_ms       (req_time_ms),
      .req_target_rpm    (req_target_rpm),
      .rsp_drive         (rsp_drive),
      .rsp_velocity_q8   (rsp_velocity_q8),
      .rsp_speed_error   (rsp_speed_error)
   );

endmodule

`default_nettype wire

>>> design/pvc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvc_div
   import pvc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [NumW-1:0] num,
   input  wire logic [DenW-1:0] den,
   output logic                 busy,
   output logic [NumW-1:0]      quo
);

   logic [NumW-1:0]   q_ff, q_in;
   logic [DenW-1:0]   rem_ff, rem_in;
   logic [DenW-1:0]   den_ff, den_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DenW:0]     shifted;
   logic [DenW:0]     diff;

   always_comb begin
      shifted = {rem_ff, q_ff[NumW-1]};
      diff    = shifted - {1'b0, den_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CountW'(NumW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DenW]) begin
            rem_in = diff[DenW-1:0];
            q_in   = {q_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DenW-1:0];
            q_in   = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = q_ff;

endmodule

`default_nettype wire

>>> design/pvc_datapath.sv
// Datapath: configuration registers, loop state, shared multiplier and divider.
// Depends on pvc_pkg and pvc_div.
`timescale 1ns / 1ps
`default_nettype none

module pvc_datapath
   import pvc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output status_type                     status,
   input  wire logic                      csr_write,
   input  wire logic [IndexW-1:0]         csr_index,
   input  wire logic [GainW-1:0]          csr_data,
   input  wire logic signed [DataW-1:0]   req_encoder_count,
   input  wire logic [DataW-1:0]          req_time_ms,
   input  wire logic signed [TargetW-1:0] req_target_rpm,
   output logic [DriveW-1:0]              rsp_drive,
   output logic signed [DataW-1:0]        rsp_velocity_q8,
   output logic signed [DataW-1:0]        rsp_speed_error
);

   logic [GainW-1:0] gain_p_ff, gain_i_ff, gain_d_ff, ticks_ff;
   logic [DataW-1:0] prev_time_ff, prev_count_ff;
   logic signed [DataW-1:0] velocity_ff, error_sum_ff, prev_error_ff, slope_ff;
   logic signed [DataW-1:0] error_ff, dcount_ff;
   logic [DataW-1:0] dtime_ff;
   logic signed [TargetW-1:0] target_ff;
   logic [NumW-1:0] num_ff;
   logic [DenW-1:0] den_ff;
   logic neg_ff;
   logic signed [AccW-1:0] acc_ff;
   logic [DriveW-1:0] drive_ff;
   logic signed [DataW-1:0] vel_out_ff, err_out_ff;

   logic signed [MulW-1:0]  mul_a, mul_b;
   logic signed [ProdW-1:0] prod;
   logic [GainW-1:0]        ticks_eff;
   logic                    div_busy;
   logic [NumW-1:0]         quo;
   logic signed [DataW+1:0] err_wide, err_adj;
   logic signed [ProdW:0]   sum_wide;
   logic signed [DataW:0]   slope_diff;
   logic [DriveW-1:0]       drive_val;

   assign ticks_eff = (ticks_ff == '0) ? GainW'(1) : ticks_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_VNUM: begin
            mul_a = MulW'(dcount_ff);
            mul_b = VelScale;
         end
         OP_VDEN: begin
            mul_a = {1'b0, dtime_ff};
            mul_b = {{(MulW-GainW){1'b0}}, ticks_eff};
         end
         OP_ISUM: begin
            mul_a = MulW'(error_ff);
            mul_b = {1'b0, dtime_ff};
         end
         OP_ACCP: begin
            mul_a = MulW'(error_ff);
            mul_b = {{(MulW-GainW){1'b0}}, gain_p_ff};
         end
         OP_ACCI: begin
            mul_a = MulW'(error_sum_ff);
            mul_b = {{(MulW-GainW){1'b0}}, gain_i_ff};
         end
         OP_ACCD: begin
            mul_a = MulW'(slope_ff);
            mul_b = {{(MulW-GainW){1'b0}}, gain_d_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = mul_a * mul_b;
   end

   pvc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .busy  (div_busy),
      .quo   (quo)
   );

   always_comb begin
      err_wide   = {{(DataW+2-TargetW-8){target_ff[TargetW-1]}}, target_ff, 8'b0}
                   - (DataW+2)'(velocity_ff);
      err_adj    = err_wide[DataW+1] ? (err_wide + (DataW+2)'(255)) : err_wide;
      sum_wide   = (ProdW+1)'(error_sum_ff) + (ProdW+1)'(prod);
      slope_diff = (DataW+1)'(error_ff) - (DataW+1)'(prev_error_ff);
      if (acc_ff[AccW-1]) begin
         drive_val = '0;
      end else if (acc_ff[AccW-1:8] > (AccW-8)'(DriveMax)) begin
         drive_val = DriveMax;
      end else begin
         drive_val = acc_ff[DriveW+7:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         ticks_ff      <= GainW'(4181);
         prev_time_ff  <= '0;
         prev_count_ff <= '0;
         velocity_ff   <= '0;
         error_sum_ff  <= '0;
         prev_error_ff <= '0;
         slope_ff      <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_GAIN_P: gain_p_ff <= csr_data;
               CSR_GAIN_I: gain_i_ff <= csr_data;
               CSR_GAIN_D: gain_d_ff <= csr_data;
               CSR_TICKS:  ticks_ff  <= csr_data;
               default: begin
               end
            endcase
         end
         case (cmd.op)
            OP_LOAD: begin
               prev_time_ff  <= req_time_ms;
               prev_count_ff <= req_encoder_count;
            end
            OP_VSET: begin
               if (!neg_ff) begin
                  velocity_ff <= (quo > NumW'(32'h7FFF_FFFF)) ?
                                 32'sh7FFF_FFFF : signed'(quo[DataW-1:0]);
               end else begin
                  velocity_ff <= (quo > NumW'(33'h0_8000_0000)) ?
                                 32'sh8000_0000 : -signed'(quo[DataW-1:0]);
               end
            end
            OP_ISUM: begin
               if (sum_wide > (ProdW+1)'(32'sh7FFF_FFFF)) begin
                  error_sum_ff <= 32'sh7FFF_FFFF;
               end else if (sum_wide < (ProdW+1)'(32'sh8000_0000)) begin
                  error_sum_ff <= 32'sh8000_0000;
               end else begin
                  error_sum_ff <= sum_wide[DataW-1:0];
               end
            end
            OP_SSET: begin
               slope_ff <= neg_ff ? -signed'(quo[DataW-1:0]) : signed'(quo[DataW-1:0]);
            end
            OP_OUT: begin
               prev_error_ff <= error_ff;
            end
            default: begin
            end
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            dtime_ff  <= req_time_ms - prev_time_ff;
            dcount_ff <= req_encoder_count - prev_count_ff;
            target_ff <= req_target_rpm;
         end
         OP_VNUM: begin
            neg_ff <= prod[ProdW-1];
            num_ff <= prod[ProdW-1] ? NumW'(-prod) : NumW'(prod);
         end
         OP_VDEN: begin
            den_ff <= prod[DenW-1:0];
         end
         OP_ERR: begin
            error_ff <= err_adj[DataW+1:8] == '0 ? '0 : DataW'(err_adj >>> 8);
         end
         OP_SNUM: begin
            neg_ff <= slope_diff[DataW];
            num_ff <= slope_diff[DataW] ? NumW'(-slope_diff) : NumW'(slope_diff);
            den_ff <= DenW'(dtime_ff);
         end
         OP_ACCP: acc_ff <= AccW'(prod);
         OP_ACCI: acc_ff <= acc_ff + AccW'(prod);
         OP_ACCD: acc_ff <= acc_ff + AccW'(prod);
         OP_OUT: begin
            drive_ff   <= drive_val;
            vel_out_ff <= velocity_ff;
            err_out_ff <= error_ff;
         end
         default: begin
         end
      endcase
   end

   assign status.dt_zero  = (dtime_ff == '0);
   assign status.div_busy = div_busy;

   assign rsp_drive       = drive_ff;
   assign rsp_velocity_q8 = vel_out_ff;
   assign rsp_speed_error = err_out_ff;

endmodule

`default_nettype wire

>>> design/pvc_ctrl.sv
// Controller state machine sequencing the datapath for one item at a time.
// Depends on pvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvc_ctrl
   import pvc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [15:0] {
      ST_IDLE = 16'b0000_0000_0000_0001,
      ST_VNUM = 16'b0000_0000_0000_0010,
      ST_VDEN = 16'b0000_0000_0000_0100,
      ST_VGO  = 16'b0000_0000_0000_1000,
      ST_VDIV = 16'b0000_0000_0001_0000,
      ST_VSET = 16'b0000_0000_0010_0000,
      ST_ERR  = 16'b0000_0000_0100_0000,
      ST_ISUM = 16'b0000_0000_1000_0000,
      ST_SNUM = 16'b0000_0001_0000_0000,
      ST_SGO  = 16'b0000_0010_0000_0000,
      ST_SDIV = 16'b0000_0100_0000_0000,
      ST_SSET = 16'b0000_1000_0000_0000,
      ST_ACCP = 16'b0001_0000_0000_0000,
      ST_ACCI = 16'b0010_0000_0000_0000,
      ST_ACCD = 16'b0100_0000_0000_0000,
      ST_DONE = 16'b1000_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd.op        = OP_NONE;
      cmd.div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_VNUM;
            end
         end
         ST_VNUM: begin
            cmd.op   = OP_VNUM;
            state_in = status.dt_zero ? ST_ERR : ST_VDEN;
         end
         ST_VDEN: begin
            cmd.op   = OP_VDEN;
            state_in = ST_VGO;
         end
         ST_VGO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_VDIV;
         end
         ST_VDIV: begin
            if (!status.div_busy) begin
               state_in = ST_VSET;
            end
         end
         ST_VSET: begin
            cmd.op   = OP_VSET;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.op   = OP_ERR;
            state_in = ST_ISUM;
         end
         ST_ISUM: begin
            cmd.op   = OP_ISUM;
            state_in = status.dt_zero ? ST_ACCP : ST_SNUM;
         end
         ST_SNUM: begin
            cmd.op   = OP_SNUM;
            state_in = ST_SGO;
         end
         ST_SGO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_SDIV;
         end
         ST_SDIV: begin
            if (!status.div_busy) begin
               state_in = ST_SSET;
            end
         end
         ST_SSET: begin
            cmd.op   = OP_SSET;
            state_in = ST_ACCP;
         end
         ST_ACCP: begin
            cmd.op   = OP_ACCP;
            state_in = ST_ACCI;
         end
         ST_ACCI: begin
            cmd.op   = OP_ACCI;
            state_in = ST_ACCD;
         end
         ST_ACCD: begin
            cmd.op   = OP_ACCD;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
